// ===== hw/rtl/olte_pkg.sv =====
// Shared constants, request and status codes, and the controller command type.
package olte_pkg;

	localparam int DEPTH       = 64;
	localparam int HANDLE_BITS = 16;
	localparam int KEY_BITS    = 16;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int REQ_W       = 4;
	localparam int POS_W       = 7;
	localparam int STATUS_W    = 3;
	localparam int FPOS_W      = 6;
	localparam int CMP_W       = (POS_W > CNT_W) ? POS_W : CNT_W;

	localparam logic [REQ_W-1:0] REQ_INS_HEAD = 4'd0;
	localparam logic [REQ_W-1:0] REQ_INS_TAIL = 4'd1;
	localparam logic [REQ_W-1:0] REQ_INS_POS  = 4'd2;
	localparam logic [REQ_W-1:0] REQ_RM_HEAD  = 4'd3;
	localparam logic [REQ_W-1:0] REQ_RM_TAIL  = 4'd4;
	localparam logic [REQ_W-1:0] REQ_RM_POS   = 4'd5;
	localparam logic [REQ_W-1:0] REQ_SEARCH   = 4'd6;
	localparam logic [REQ_W-1:0] REQ_READ     = 4'd7;
	localparam logic [REQ_W-1:0] REQ_WRITE    = 4'd8;
	localparam logic [REQ_W-1:0] REQ_CLEAR    = 4'd9;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic capture;
		logic eval;
		logic commit;
	} cmd_t;

endpackage

// ===== hw/rtl/ordered_list_table_engine.sv =====
// Top level of the ordered list table engine: controller plus datapath.
//
// An ordered list of up to 64 entries, each a 16-bit handle and a 16-bit key.
// Requests enter on the input channel (in_valid, in_stall, req_type, position,
// item_handle, item_key) and insert, remove, search, read, write or clear.
// Each item yields exactly one result on the output channel (out_valid,
// out_stall, status, out_handle, out_key, found_position, entry_count,
// is_empty). An item is taken when valid is high and stall is low.
// Each item is captured, then decoded with its key matched against all
// entries in parallel, then committed: the entry cells are shifted or
// written and the output register is loaded. The result appears the cycle
// after commit, and no new item is accepted until the current one commits.
// The output register lets the next item be accepted while a result waits;
// if the receiver still stalls at commit time, commit waits and the input
// stays stalled until the old result is taken.
// Reset (arst_n low) empties the list and drops any pending result; entry
// contents are not cleared and need no clearing pass.
module ordered_list_table_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [olte_pkg::REQ_W-1:0]          req_type,
	input  logic [olte_pkg::POS_W-1:0]          position,
	input  logic [olte_pkg::HANDLE_BITS-1:0]    item_handle,
	input  logic [olte_pkg::KEY_BITS-1:0]       item_key,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [olte_pkg::STATUS_W-1:0]       status,
	output logic [olte_pkg::HANDLE_BITS-1:0]    out_handle,
	output logic [olte_pkg::KEY_BITS-1:0]       out_key,
	output logic [olte_pkg::FPOS_W-1:0]         found_position,
	output logic [olte_pkg::CNT_W-1:0]          entry_count,
	output logic                                is_empty
);

	olte_pkg::cmd_t cmd;

	olte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	olte_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_type       (req_type),
		.position       (position),
		.item_handle    (item_handle),
		.item_key       (item_key),
		.status         (status),
		.out_handle     (out_handle),
		.out_key        (out_key),
		.found_position (found_position),
		.entry_count    (entry_count),
		.is_empty       (is_empty)
	);

endmodule

// ===== hw/rtl/olte_ctrl.sv =====
// Controller state machine: sequences capture, evaluation and commit of each item.
module olte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output olte_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free    = !out_valid_q || !out_stall;
	assign cmd.capture = (state_q == S_IDLE) && in_valid;
	assign cmd.eval    = (state_q == S_EVAL);
	assign cmd.commit  = (state_q == S_COMMIT) && out_free;
	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A commit loads a fresh result; otherwise a taken result empties the register.
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/olte_datapath.sv =====
// Datapath: entry cells, count, request decode, key match and shift update.
module olte_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  olte_pkg::cmd_t                      cmd,
	input  logic [olte_pkg::REQ_W-1:0]          req_type,
	input  logic [olte_pkg::POS_W-1:0]          position,
	input  logic [olte_pkg::HANDLE_BITS-1:0]    item_handle,
	input  logic [olte_pkg::KEY_BITS-1:0]       item_key,
	output logic [olte_pkg::STATUS_W-1:0]       status,
	output logic [olte_pkg::HANDLE_BITS-1:0]    out_handle,
	output logic [olte_pkg::KEY_BITS-1:0]       out_key,
	output logic [olte_pkg::FPOS_W-1:0]         found_position,
	output logic [olte_pkg::CNT_W-1:0]          entry_count,
	output logic                                is_empty
);

	localparam int D  = olte_pkg::DEPTH;
	localparam int IW = olte_pkg::IDX_W;
	localparam int CW = olte_pkg::CNT_W;
	localparam int HB = olte_pkg::HANDLE_BITS;
	localparam int KB = olte_pkg::KEY_BITS;

	// Captured request.
	logic [olte_pkg::REQ_W-1:0]  req_q;
	logic [olte_pkg::POS_W-1:0]  pos_q;
	logic [HB-1:0]               hdl_q;
	logic [KB-1:0]               key_q;

	// Entry cells and fill count.
	logic [HB-1:0] cell_hdl_q [D];
	logic [KB-1:0] cell_key_q [D];
	logic [CW-1:0] count_q;

	// Decoded operation, held from evaluation to commit.
	logic [olte_pkg::STATUS_W-1:0] st_q;
	logic [IW-1:0]                 idx_q;
	logic                          do_ins_q;
	logic                          do_rm_q;
	logic                          do_wr_q;
	logic                          do_clr_q;
	logic                          ret_q;
	logic                          found_q;

	// Output register.
	logic [olte_pkg::STATUS_W-1:0] st_o_q;
	logic [HB-1:0]                 oh_o_q;
	logic [KB-1:0]                 ok_o_q;
	logic [olte_pkg::FPOS_W-1:0]   fp_o_q;

	// Evaluation logic.
	logic [D-1:0]                  hit;
	logic [IW-1:0]                 first_idx;
	logic                          any_hit;
	logic [olte_pkg::CMP_W-1:0]    pos_x;
	logic [olte_pkg::CMP_W-1:0]    cnt_x;
	logic                          full;
	logic                          empty;
	logic                          pos_gt_cnt;
	logic                          pos_ge_cnt;
	logic [IW-1:0]                 last_idx;
	logic [olte_pkg::STATUS_W-1:0] st_d;
	logic [IW-1:0]                 idx_d;
	logic                          do_ins_d;
	logic                          do_rm_d;
	logic                          do_wr_d;
	logic                          do_clr_d;
	logic                          ret_d;
	logic                          found_d;

	assign pos_x      = olte_pkg::CMP_W'(pos_q);
	assign cnt_x      = olte_pkg::CMP_W'(count_q);
	assign full       = (count_q == CW'(D));
	assign empty      = (count_q == '0);
	assign pos_gt_cnt = (pos_x > cnt_x);
	assign pos_ge_cnt = (pos_x >= cnt_x);
	assign last_idx   = IW'(count_q - CW'(1));

	always_comb begin
		for (int i = 0; i < D; i++) begin
			hit[i] = (cell_key_q[i] == key_q) && (CW'(i) < count_q);
		end
	end

	// Lowest matching cell wins.
	always_comb begin
		first_idx = '0;
		for (int i = D - 1; i >= 0; i--) begin
			if (hit[i]) begin
				first_idx = IW'(i);
			end
		end
		any_hit = |hit;
	end

	always_comb begin
		st_d     = olte_pkg::ST_OK;
		idx_d    = '0;
		do_ins_d = 1'b0;
		do_rm_d  = 1'b0;
		do_wr_d  = 1'b0;
		do_clr_d = 1'b0;
		ret_d    = 1'b0;
		found_d  = 1'b0;
		case (req_q)
			olte_pkg::REQ_INS_HEAD, olte_pkg::REQ_INS_TAIL, olte_pkg::REQ_INS_POS: begin
				if (full) begin
					st_d = olte_pkg::ST_FULL;
				end else if (req_q == olte_pkg::REQ_INS_HEAD) begin
					do_ins_d = 1'b1;
				end else if (req_q == olte_pkg::REQ_INS_TAIL) begin
					do_ins_d = 1'b1;
					idx_d    = count_q[IW-1:0];
				end else if (pos_gt_cnt) begin
					st_d = olte_pkg::ST_BADPOS;
				end else begin
					do_ins_d = 1'b1;
					idx_d    = pos_q[IW-1:0];
				end
			end
			olte_pkg::REQ_RM_HEAD, olte_pkg::REQ_RM_TAIL: begin
				if (empty) begin
					st_d = olte_pkg::ST_EMPTY;
				end else begin
					do_rm_d = 1'b1;
					ret_d   = 1'b1;
					idx_d   = (req_q == olte_pkg::REQ_RM_HEAD) ? '0 : last_idx;
				end
			end
			olte_pkg::REQ_RM_POS: begin
				if (pos_ge_cnt) begin
					st_d = olte_pkg::ST_BADPOS;
				end else begin
					do_rm_d = 1'b1;
					ret_d   = 1'b1;
					idx_d   = pos_q[IW-1:0];
				end
			end
			olte_pkg::REQ_SEARCH: begin
				if (empty) begin
					st_d = olte_pkg::ST_EMPTY;
				end else if (!any_hit) begin
					st_d = olte_pkg::ST_NOTFOUND;
				end else begin
					ret_d   = 1'b1;
					found_d = 1'b1;
					idx_d   = first_idx;
				end
			end
			olte_pkg::REQ_READ: begin
				if (pos_ge_cnt) begin
					st_d = olte_pkg::ST_BADPOS;
				end else begin
					ret_d = 1'b1;
					idx_d = pos_q[IW-1:0];
				end
			end
			olte_pkg::REQ_WRITE: begin
				if (pos_ge_cnt) begin
					st_d = olte_pkg::ST_BADPOS;
				end else begin
					do_wr_d = 1'b1;
					idx_d   = pos_q[IW-1:0];
				end
			end
			olte_pkg::REQ_CLEAR: begin
				do_clr_d = 1'b1;
			end
			default: begin
				st_d = olte_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			pos_q <= position;
			hdl_q <= item_handle;
			key_q <= item_key;
		end
		if (cmd.eval) begin
			st_q     <= st_d;
			idx_q    <= idx_d;
			ret_q    <= ret_d;
			found_q  <= found_d;
		end
		if (cmd.commit) begin
			st_o_q <= st_q;
			oh_o_q <= ret_q ? cell_hdl_q[idx_q] : '0;
			ok_o_q <= ret_q ? cell_key_q[idx_q] : '0;
			fp_o_q <= found_q ? olte_pkg::FPOS_W'(idx_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			do_ins_q <= 1'b0;
			do_rm_q  <= 1'b0;
			do_wr_q  <= 1'b0;
			do_clr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (cmd.eval) begin
				do_ins_q <= do_ins_d;
				do_rm_q  <= do_rm_d;
				do_wr_q  <= do_wr_d;
				do_clr_q <= do_clr_d;
			end
			if (cmd.commit) begin
				if (do_clr_q) begin
					count_q <= '0;
				end else if (do_ins_q) begin
					count_q <= count_q + CW'(1);
				end else if (do_rm_q) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// Insert shifts cells above idx_q up; remove shifts cells from idx_q down.
	for (genvar i = 0; i < D; i++) begin : g_cell
		logic [HB-1:0] below_hdl;
		logic [KB-1:0] below_key;
		logic [HB-1:0] above_hdl;
		logic [KB-1:0] above_key;

		if (i == 0) begin : g_first
			assign below_hdl = '0;
			assign below_key = '0;
		end else begin : g_mid_lo
			assign below_hdl = cell_hdl_q[i-1];
			assign below_key = cell_key_q[i-1];
		end
		if (i == D - 1) begin : g_last
			assign above_hdl = cell_hdl_q[i];
			assign above_key = cell_key_q[i];
		end else begin : g_mid_hi
			assign above_hdl = cell_hdl_q[i+1];
			assign above_key = cell_key_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.commit) begin
				if (do_ins_q) begin
					if (IW'(i) == idx_q) begin
						cell_hdl_q[i] <= hdl_q;
						cell_key_q[i] <= key_q;
					end else if (IW'(i) > idx_q) begin
						cell_hdl_q[i] <= below_hdl;
						cell_key_q[i] <= below_key;
					end
				end else if (do_rm_q) begin
					if (IW'(i) >= idx_q) begin
						cell_hdl_q[i] <= above_hdl;
						cell_key_q[i] <= above_key;
					end
				end else if (do_wr_q) begin
					if (IW'(i) == idx_q) begin
						cell_hdl_q[i] <= hdl_q;
						cell_key_q[i] <= key_q;
					end
				end
			end
		end
	end

	assign status         = st_o_q;
	assign out_handle     = oh_o_q;
	assign out_key        = ok_o_q;
	assign found_position = fp_o_q;
	assign entry_count    = count_q;
	assign is_empty       = (count_q == '0);

endmodule
